FILE: rtl/core/rprt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Received packet range tracker package
// Sizes, result codes and the range table entry layout shared by the block.
// ----------------------------------------------------------------------------
package rprt_pkg;

	localparam int MAX_RANGES       = 32;
	localparam int MAX_FRAME_RANGES = 16;
	localparam int IDX_W            = $clog2(MAX_RANGES);
	localparam int CNT_W            = $clog2(MAX_RANGES + 1);
	localparam int FR_W             = $clog2(MAX_FRAME_RANGES + 1);
	localparam int PN_W             = 62;
	localparam int TIME_W           = 64;
	localparam int DELAY_W          = 24;
	localparam int ENTRY_W          = 2 * PN_W;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_RANGE  = 2'd2;
	localparam logic [1:0] KIND_EMPTY  = 2'd3;

	localparam logic [1:0] ST_RECORDED = 2'd0;
	localparam logic [1:0] ST_DUP      = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic ACT_RECEIVE = 1'b0;
	localparam logic ACT_BUILD   = 1'b1;

	localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd25000;

	typedef struct packed {
		logic [PN_W-1:0] lo;
		logic [PN_W-1:0] hi;
	} entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/rprt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read, no reset.
// ----------------------------------------------------------------------------
module rprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/received_packet_range_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Received packet range tracker
// Holds received packet numbers as disjoint ranges in one RAM and builds
// acknowledgement frames from them.
// ----------------------------------------------------------------------------
// A receive item scans the stored ranges, decides, then makes at most one
// write and shifts the entries behind the edit before its status result. A
// build item emits one result per range it covers, or a single empty result
// when no ranges are held. One item at a time; the receiver cannot stall.
// Reset clears the count, largest number and ack state.
// ----------------------------------------------------------------------------
module received_packet_range_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [61:0] pkt_number,
	input  wire logic [63:0] now_us,
	input  wire logic        wants_ack,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data,
	output logic             res_strobe,
	output logic [1:0]       kind,
	output logic [1:0]       recv_status,
	output logic [61:0]      top_acked,
	output logic [63:0]      ack_wait,
	output logic [61:0]      first_range,
	output logic [61:0]      gap,
	output logic [61:0]      range_len,
	output logic             last,
	output logic             ack_owed,
	output logic [63:0]      ack_deadline
);

	localparam int PW = rprt_pkg::PN_W;
	localparam int TW = rprt_pkg::TIME_W;
	localparam int IW = rprt_pkg::IDX_W;
	localparam int CW = rprt_pkg::CNT_W;

	// The sequencer walks through one-hot states; streaming states issue one
	// RAM read per cycle and handle the returned entry in the next cycle.
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_DECIDE = 9'b000000100,
		S_WR     = 9'b000001000,
		S_SHDN   = 9'b000010000,
		S_SHUP   = 9'b000100000,
		S_INS    = 9'b001000000,
		S_DONE   = 9'b010000000,
		S_BUILD  = 9'b100000000
	} state_t;

	state_t state_q;

	// Item registers.
	logic [PW-1:0] p_q;
	logic [TW-1:0] now_q;
	logic          elicit_q;

	// Persistent tracker state.
	logic [CW-1:0]                   cnt_q;
	logic [PW-1:0]                   largest_q;
	logic [TW-1:0]                   largest_time_q;
	logic                            ack_pend_q;
	logic [TW-1:0]                   ack_due_q;
	logic [rprt_pkg::DELAY_W-1:0]    max_delay_q;

	// Read stream.
	logic [CW-1:0] idx_q;
	logic [CW-1:0] rem_q;
	logic          rv_s1;
	logic [IW-1:0] ri_s1;
	logic          issue_en;
	rprt_pkg::entry_t rd_ent;
	logic [PW-1:0] prev_lo_q;
	logic [PW-1:0] prev_hi_q;

	// Scan findings.
	logic          dup_q;
	logic          found_q;
	logic          pendb_q;
	logic          drop_q;
	logic [IW-1:0] d_q;
	logic [IW-1:0] w_addr_q;
	logic [PW-1:0] w_lo_q;
	logic [PW-1:0] w_hi_q;
	logic [CW-1:0] pos_q;
	logic [1:0]    status_q;
	logic [1:0]    done_kind_q;

	// Frame building.
	logic [rprt_pkg::FR_W-1:0] nrange_q;
	logic [1:0]    pk_kind_q;
	logic [PW-1:0] pk_a_q;
	logic [TW-1:0] pk_delay_q;
	logic [PW-1:0] pk_first_q;
	logic [PW-1:0] pk_gap_q;
	logic [PW-1:0] pk_len_q;

	// RAM ports.
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [rprt_pkg::ENTRY_W-1:0] ram_wdata;
	logic [rprt_pkg::ENTRY_W-1:0] ram_rdata;

	rprt_ram #(
		.WIDTH(rprt_pkg::ENTRY_W),
		.DEPTH(rprt_pkg::MAX_RANGES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[IW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_ent    = rprt_pkg::entry_t'(ram_rdata);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ack_owed     = ack_pend_q;
	assign ack_deadline = ack_due_q;

	assign issue_en = (rem_q != '0) &&
		((state_q == S_SCAN) || (state_q == S_SHDN) ||
		 (state_q == S_SHUP) || (state_q == S_BUILD));

	// Comparisons on the returned entry, done one bit wider so that +1 and
	// +2 never wrap.
	logic [PW:0] p_x, lo_x, hi_x, plo_x;
	logic        in_range, hit_a, hit_b, below_p, join_b, touch;
	assign p_x   = {1'b0, p_q};
	assign lo_x  = {1'b0, rd_ent.lo};
	assign hi_x  = {1'b0, rd_ent.hi};
	assign plo_x = {1'b0, prev_lo_q};
	assign in_range = (p_q >= rd_ent.lo) && (p_q <= rd_ent.hi);
	assign hit_a    = (p_x == hi_x + 1'b1);
	assign hit_b    = (p_x + 1'b1 == lo_x);
	assign below_p  = (rd_ent.lo > p_q);
	assign join_b   = (hi_x + 1'b1 == p_x);
	assign touch    = (plo_x < hi_x + 2'd2);

	logic [TW-1:0] delay_now;
	assign delay_now = (now_q > largest_time_q) ? (now_q - largest_time_q) : '0;

	// RAM write selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_addr_q;
		ram_wdata = {w_lo_q, w_hi_q};
		case (state_q)
			S_WR: begin
				ram_we = 1'b1;
			end
			S_INS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[IW-1:0];
				ram_wdata = {p_q, p_q};
			end
			S_SHDN: begin
				ram_we    = rv_s1;
				ram_waddr = ri_s1 - 1'b1;
				ram_wdata = ram_rdata;
			end
			S_SHUP: begin
				ram_we    = rv_s1;
				ram_waddr = ri_s1 + 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Read stream bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= issue_en;
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= idx_q[IW-1:0];
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			largest_q      <= '0;
			largest_time_q <= '0;
			ack_pend_q     <= 1'b0;
			ack_due_q      <= '0;
			max_delay_q    <= rprt_pkg::DELAY_RESET;
			rem_q          <= '0;
			idx_q          <= '0;
			res_strobe     <= 1'b0;
		end else begin
			res_strobe <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				max_delay_q <= cfg_data;
			end
			if (issue_en) begin
				rem_q <= rem_q - 1'b1;
				if (state_q == S_SHUP) begin
					idx_q <= idx_q - 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						dup_q    <= 1'b0;
						found_q  <= 1'b0;
						pendb_q  <= 1'b0;
						drop_q   <= 1'b0;
						pos_q    <= '0;
						nrange_q <= '0;
						idx_q    <= '0;
						rem_q    <= cnt_q;
						if (action == rprt_pkg::ACT_RECEIVE) begin
							state_q <= S_SCAN;
						end else if (cnt_q == '0) begin
							done_kind_q <= rprt_pkg::KIND_EMPTY;
							status_q    <= rprt_pkg::ST_RECORDED;
							state_q     <= S_DONE;
						end else begin
							state_q <= S_BUILD;
						end
					end
				end
				S_SCAN: begin
					if (rv_s1) begin
						prev_lo_q <= rd_ent.lo;
						prev_hi_q <= rd_ent.hi;
						if (in_range) begin
							dup_q <= 1'b1;
						end
						if (below_p) begin
							pos_q <= pos_q + 1'b1;
						end
						if (!found_q) begin
							if (hit_a) begin
								found_q <= 1'b1;
								if ((ri_s1 != '0) && (plo_x == p_x + 1'b1)) begin
									// The new number closes the gap to the range above.
									w_addr_q <= ri_s1 - 1'b1;
									w_lo_q   <= rd_ent.lo;
									w_hi_q   <= prev_hi_q;
									drop_q   <= 1'b1;
									d_q      <= ri_s1;
								end else begin
									w_addr_q <= ri_s1;
									w_lo_q   <= rd_ent.lo;
									w_hi_q   <= p_q;
								end
							end else if (hit_b) begin
								found_q  <= 1'b1;
								pendb_q  <= 1'b1;
								w_addr_q <= ri_s1;
								w_lo_q   <= p_q;
								w_hi_q   <= rd_ent.hi;
							end
						end else if (pendb_q) begin
							pendb_q <= 1'b0;
							if (join_b) begin
								// The range below now touches: absorb it.
								w_lo_q <= rd_ent.lo;
								drop_q <= 1'b1;
								d_q    <= ri_s1;
							end
						end
					end else if (rem_q == '0) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					done_kind_q <= rprt_pkg::KIND_STATUS;
					if (dup_q) begin
						status_q <= rprt_pkg::ST_DUP;
						state_q  <= S_DONE;
					end else begin
						if ((cnt_q == '0) || (p_q > largest_q)) begin
							largest_q      <= p_q;
							largest_time_q <= now_q;
						end
						if (elicit_q) begin
							ack_pend_q <= 1'b1;
							ack_due_q  <= now_q + TW'(max_delay_q);
						end
						status_q <= rprt_pkg::ST_RECORDED;
						if (found_q) begin
							state_q <= S_WR;
							if (drop_q) begin
								cnt_q <= cnt_q - 1'b1;
								rem_q <= cnt_q - 1'b1 - CW'(d_q);
								idx_q <= CW'(d_q) + 1'b1;
							end else begin
								rem_q <= '0;
							end
						end else if (cnt_q < CW'(rprt_pkg::MAX_RANGES)) begin
							state_q <= S_SHUP;
							cnt_q   <= cnt_q + 1'b1;
							rem_q   <= cnt_q - pos_q;
							idx_q   <= cnt_q - 1'b1;
						end else begin
							status_q <= rprt_pkg::ST_FULL;
							state_q  <= S_DONE;
						end
					end
				end
				S_WR: begin
					state_q <= drop_q ? S_SHDN : S_DONE;
				end
				S_SHDN: begin
					if (!rv_s1 && (rem_q == '0)) begin
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					if (!rv_s1 && (rem_q == '0)) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					res_strobe    <= 1'b1;
					kind          <= done_kind_q;
					recv_status   <= status_q;
					top_acked     <= '0;
					ack_wait      <= '0;
					first_range   <= '0;
					gap           <= '0;
					range_len     <= '0;
					last          <= 1'b1;
					state_q       <= S_IDLE;
				end
				S_BUILD: begin
					if (rv_s1) begin
						prev_lo_q <= rd_ent.lo;
						prev_hi_q <= rd_ent.hi;
						if (ri_s1 == '0) begin
							pk_kind_q  <= rprt_pkg::KIND_HEADER;
							pk_a_q     <= rd_ent.hi;
							pk_delay_q <= delay_now;
							pk_first_q <= rd_ent.hi - rd_ent.lo;
							pk_gap_q   <= '0;
							pk_len_q   <= '0;
						end else begin
							res_strobe    <= 1'b1;
							kind          <= pk_kind_q;
							recv_status   <= rprt_pkg::ST_RECORDED;
							top_acked     <= pk_a_q;
							ack_wait      <= pk_delay_q;
							first_range   <= pk_first_q;
							gap           <= pk_gap_q;
							range_len     <= pk_len_q;
							if (touch || (nrange_q ==
								rprt_pkg::FR_W'(rprt_pkg::MAX_FRAME_RANGES))) begin
								last    <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								last       <= 1'b0;
								nrange_q   <= nrange_q + 1'b1;
								pk_kind_q  <= rprt_pkg::KIND_RANGE;
								pk_a_q     <= '0;
								pk_delay_q <= '0;
								pk_first_q <= '0;
								pk_gap_q   <= prev_lo_q - rd_ent.hi - 2'd2;
								pk_len_q   <= rd_ent.hi - rd_ent.lo;
							end
						end
					end else if (rem_q == '0) begin
						res_strobe    <= 1'b1;
						kind          <= pk_kind_q;
						recv_status   <= rprt_pkg::ST_RECORDED;
						top_acked     <= pk_a_q;
						ack_wait      <= pk_delay_q;
						first_range   <= pk_first_q;
						gap           <= pk_gap_q;
						range_len     <= pk_len_q;
						last          <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			p_q      <= pkt_number;
			now_q    <= now_us;
			elicit_q <= wants_ack;
		end
	end

	// Checks on the sequencer.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rprt_pkg::MAX_RANGES))
		else $error("range count exceeds table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && (kind == rprt_pkg::KIND_STATUS)) |-> last)
		else $error("receive status not marked last");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_strobe && (kind == rprt_pkg::KIND_EMPTY)) |-> (last && (cnt_q == '0)))
		else $error("empty frame result with ranges held");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == S_SHUP)) |-> (CW'(ram_waddr) < cnt_q))
		else $error("shift writes beyond the table");

endmodule
`default_nettype wire
